>>> hdl/sfc_pkg.sv
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared constants, action codes and the state record of the screen fade
// controller.
// ----------------------------------------------------------------------------
package sfc_pkg;

  localparam int unsigned FULL_LEVEL   = 256;
  localparam int unsigned FADE_TIME_MS = 1024;
  localparam int unsigned FALL_HOLD_MS = 512;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned TIME_W   = 31;
  localparam int unsigned LEVEL_W  = 9;
  localparam int unsigned ALPHA_W  = 8;

  // Clamped elapsed time and its product with the full level.
  localparam int unsigned DELTA_W  = $clog2(FADE_TIME_MS + 1);
  localparam int unsigned PROD_W   = DELTA_W + LEVEL_W;
  localparam int unsigned SHADE_W  = LEVEL_W + ALPHA_W;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 24;

  localparam logic [ACTION_W-1:0] ACT_TICK      = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FADE_DOWN = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FADE_UP   = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_RESTORE   = 2'd3;

  localparam logic [TIME_W-1:0]  TIME_MAX   = {TIME_W{1'b1}};
  localparam logic [LEVEL_W-1:0] LEVEL_FULL = LEVEL_W'(FULL_LEVEL);
  localparam logic [ALPHA_W-1:0] ALPHA_MAX  = 8'd255;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               rising;
    logic               falling;
    logic [TIME_W-1:0]  prev_time;
    logic               prev_valid;
    logic [TIME_W-1:0]  fall_deadline;
  } fade_state_t;

endpackage

>>> hdl/sfc_update.sv
// ----------------------------------------------------------------------------
// sfc_update
// Next-state logic of the fade controller: applies one event to the current
// brightness state.
// ----------------------------------------------------------------------------
module sfc_update (
  input  sfc_pkg::fade_state_t              cur,
  input  logic [sfc_pkg::ACTION_W-1:0]      action,
  input  logic [sfc_pkg::TIME_W-1:0]        now_ms,
  output sfc_pkg::fade_state_t              nxt
);

  logic [sfc_pkg::TIME_W-1:0]  delta;
  logic [sfc_pkg::DELTA_W-1:0] delta_clamp;
  logic [sfc_pkg::PROD_W-1:0]  prod;
  logic [sfc_pkg::PROD_W-1:0]  quot;
  logic [sfc_pkg::LEVEL_W-1:0] step;
  logic [sfc_pkg::LEVEL_W:0]   sum_up;
  logic [sfc_pkg::TIME_W:0]    deadline_sum;

  always_comb begin
    delta = now_ms - cur.prev_time;
    if (delta > sfc_pkg::TIME_W'(sfc_pkg::FADE_TIME_MS)) begin
      delta_clamp = sfc_pkg::DELTA_W'(sfc_pkg::FADE_TIME_MS);
    end else begin
      delta_clamp = delta[sfc_pkg::DELTA_W-1:0];
    end
    // The fade time is a power of two, so the divide is a shift.
    prod = sfc_pkg::PROD_W'(delta_clamp) * sfc_pkg::PROD_W'(sfc_pkg::FULL_LEVEL);
    quot = prod / sfc_pkg::PROD_W'(sfc_pkg::FADE_TIME_MS);
    // Time that stands still or runs backwards moves nothing.
    if (now_ms > cur.prev_time) begin
      step = quot[sfc_pkg::LEVEL_W-1:0];
    end else begin
      step = '0;
    end
    sum_up       = {1'b0, cur.level} + {1'b0, step};
    deadline_sum = {1'b0, now_ms} + (sfc_pkg::TIME_W+1)'(sfc_pkg::FALL_HOLD_MS);
  end

  always_comb begin
    nxt = cur;
    unique case (action)
      sfc_pkg::ACT_TICK: begin
        if (cur.rising) begin
          nxt.prev_time  = now_ms;
          nxt.prev_valid = 1'b1;
          if (cur.prev_valid) begin
            if (sum_up >= (sfc_pkg::LEVEL_W+1)'(sfc_pkg::FULL_LEVEL)) begin
              nxt.level      = sfc_pkg::LEVEL_FULL;
              nxt.rising     = 1'b0;
              nxt.prev_valid = 1'b0;
            end else begin
              nxt.level = sum_up[sfc_pkg::LEVEL_W-1:0];
            end
          end
        end
        if (cur.falling) begin
          nxt.prev_time  = now_ms;
          nxt.prev_valid = 1'b1;
          if (cur.prev_valid) begin
            nxt.level = (cur.level > step) ? cur.level - step : '0;
          end
          if (now_ms > cur.fall_deadline) begin
            nxt.falling    = 1'b0;
            nxt.prev_valid = 1'b0;
          end
        end
      end
      sfc_pkg::ACT_FADE_DOWN: begin
        if (!cur.rising) begin
          nxt.falling = 1'b1;
        end
        nxt.fall_deadline = deadline_sum[sfc_pkg::TIME_W] ? sfc_pkg::TIME_MAX
                                                          : deadline_sum[sfc_pkg::TIME_W-1:0];
        nxt.prev_valid    = 1'b0;
      end
      sfc_pkg::ACT_FADE_UP: begin
        nxt.falling    = 1'b0;
        nxt.rising     = 1'b1;
        nxt.prev_valid = 1'b0;
      end
      sfc_pkg::ACT_RESTORE: begin
        nxt.level         = sfc_pkg::LEVEL_FULL;
        nxt.rising        = 1'b0;
        nxt.falling       = 1'b0;
        nxt.prev_time     = '0;
        nxt.prev_valid    = 1'b0;
        nxt.fall_deadline = '0;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

>>> hdl/screen_fade_controller_top.sv
// ----------------------------------------------------------------------------
// screen_fade_controller_top
// Timestamped fade-down / fade-up brightness tracker with overlay alpha.
// ----------------------------------------------------------------------------
// The block takes one event per clock cycle whenever its output register is
// empty or its item is being taken in the same cycle, and returns one result
// item per event, in the cycle after the event is accepted. The state is
// updated in the cycle of acceptance by a single pass of next-state logic,
// and the result is held in the output register. Each result carries the
// brightness after the event, the busy flag and the overlay opacity.
// ----------------------------------------------------------------------------
module screen_fade_controller_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [1:0] action, [32:2] now_ms, [39:33] zero
  input  logic [sfc_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [8:0] brightness, [9] busy_res, [17:10] overlay_alpha, [23:18] zero
  output logic [sfc_pkg::OUT_DATA_W-1:0]     out_tdata
);

  sfc_pkg::fade_state_t state_r;
  sfc_pkg::fade_state_t state_nxt;

  logic [sfc_pkg::ACTION_W-1:0] in_action;
  logic [sfc_pkg::TIME_W-1:0]   in_now_ms;
  logic                         in_accept;

  logic                          out_valid_r;
  logic [sfc_pkg::LEVEL_W-1:0]   out_brightness_r;
  logic                          out_busy_r;
  logic [sfc_pkg::ALPHA_W-1:0]   out_alpha_r;

  logic [sfc_pkg::LEVEL_W-1:0]   dark;
  logic [sfc_pkg::SHADE_W-1:0]   shade;
  logic [sfc_pkg::SHADE_W-1:0]   shade_q;
  logic [sfc_pkg::ALPHA_W-1:0]   alpha_nxt;

  assign in_action = in_tdata[sfc_pkg::ACTION_W-1:0];
  assign in_now_ms = in_tdata[sfc_pkg::ACTION_W +: sfc_pkg::TIME_W];
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  sfc_update u_update (
    .cur    (state_r),
    .action (in_action),
    .now_ms (in_now_ms),
    .nxt    (state_nxt)
  );

  always_comb begin
    dark    = sfc_pkg::LEVEL_FULL - state_nxt.level;
    shade   = sfc_pkg::SHADE_W'(dark) * sfc_pkg::SHADE_W'(sfc_pkg::ALPHA_MAX);
    shade_q = shade / sfc_pkg::SHADE_W'(sfc_pkg::FULL_LEVEL);
    if (state_nxt.level >= sfc_pkg::LEVEL_FULL) begin
      alpha_nxt = '0;
    end else begin
      alpha_nxt = shade_q[sfc_pkg::ALPHA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.level         <= sfc_pkg::LEVEL_FULL;
      state_r.rising        <= 1'b0;
      state_r.falling       <= 1'b0;
      state_r.prev_time     <= '0;
      state_r.prev_valid    <= 1'b0;
      state_r.fall_deadline <= '0;
      out_valid_r           <= 1'b0;
    end else begin
      if (in_accept) begin
        state_r <= state_nxt;
      end
      if (in_accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_brightness_r <= state_nxt.level;
      out_busy_r       <= state_nxt.rising || state_nxt.falling;
      out_alpha_r      <= alpha_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_alpha_r, out_busy_r, out_brightness_r};

`ifndef SYNTHESIS
  // Fade-up and fade-down never run at the same time.
  a_not_both: assert property (@(posedge clk) disable iff (!rst_n)
    !(state_r.rising && state_r.falling))
    else $error("rising and falling both set");

  // A restore puts the block back at full brightness with no fade running.
  a_restore: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_action == sfc_pkg::ACT_RESTORE |=>
      state_r.level == sfc_pkg::LEVEL_FULL && !state_r.rising && !state_r.falling)
    else $error("restore did not return to full brightness");

  // A tick with no fade running leaves the level alone.
  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_action == sfc_pkg::ACT_TICK && !state_r.rising && !state_r.falling
      |=> state_r.level == $past(state_r.level))
    else $error("idle tick changed the level");

  // The reported opacity is zero whenever the reported level is full.
  a_alpha_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_brightness_r == sfc_pkg::LEVEL_FULL |-> out_alpha_r == '0)
    else $error("overlay not clear at full brightness");

  // The level never goes past full.
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> state_r.level <= sfc_pkg::LEVEL_FULL)
    else $error("level above full");
`endif

endmodule
